/* rtl/vertex_normal_accumulation_defines.svh */
// Assertion macros shared by the vertex normal accumulation RTL.
`ifndef VERTEX_NORMAL_ACCUMULATION_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VNA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define VNA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define VNA_ASSERT(lbl, prop, msg)
`define VNA_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* rtl/vna_pkg.sv */
// Types and constants of the vertex normal accumulation block.
`timescale 1ns / 1ps
package vna_pkg;
	localparam int IDX_W = 12;
	localparam int POS_W = 16;
	localparam int NRM_W = 20;
	localparam int UNIT_W = 16;
	localparam int UNIT_ONE = 16384;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TRI  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [IDX_W-1:0]       vertex_a;
		logic [IDX_W-1:0]       vertex_b;
		logic [IDX_W-1:0]       vertex_c;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]        vertex_out;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
	} out_word_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;
endpackage

/* rtl/vertex_normal_accumulation.sv */
// Top level of the vertex normal accumulation block.
//
//   channel   direction  handshake                   word
//   command   in         start, busy (start & !busy) item   (vna_pkg::in_word_t)
//   result    out        strobe, one cycle           result (vna_pkg::out_word_t)
//
// After reset the normal store is cleared one entry a cycle, and busy stays high until
// the last entry is cleared. A command passes the front states idle, reduce (only when
// VERTEX_COUNT < 4096, for index reduction) and push, then waits in a two-word queue
// for the back part, which takes a load or a read in its idle state. A read is flagged
// in read_out_q, and the result register then takes its word for the ports and strobe.
// A triangle passes the shift-per-cycle normalizer, the bit-serial square root and the
// divider; a degenerate face returns to idle from the normalizer.
// The result receiver cannot stall.
`timescale 1ns / 1ps
module vertex_normal_accumulation #(
	parameter int VERTEX_COUNT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  vna_pkg::in_word_t  item,
	output logic               strobe,
	output vna_pkg::out_word_t result
);
	import vna_pkg::*;

	back_status_t status;
	logic         push;
	in_word_t     push_word;
	logic         queue_full;
	logic         pop;
	logic         head_valid;
	in_word_t     head;

	vna_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.status     (status),
		.queue_full (queue_full),
		.push       (push),
		.push_word  (push_word)
	);

	vna_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	vna_back #(.VERTEX_COUNT(VERTEX_COUNT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.status     (status),
		.strobe     (strobe),
		.result     (result)
	);
endmodule

/* rtl/vna_queue.sv */
// Two-entry word queue between the front and back parts.
`timescale 1ns / 1ps
`include "vertex_normal_accumulation_defines.svh"
module vna_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vna_pkg::in_word_t push_word,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output vna_pkg::in_word_t head
);
	import vna_pkg::*;

	in_word_t  mem_q [2];
	logic      wr_q;
	logic      rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign full       = cnt_q[1];
	assign head_valid = cnt_q != 2'd0;
	assign head       = mem_q[rd_q];

	`VNA_ASSERT_IMP(a_no_push_full, full, !push, "word pushed into a full queue")
	`VNA_ASSERT_IMP(a_no_pop_empty, !head_valid, !pop, "word popped from an empty queue")
	`VNA_ASSERT(a_count_range, cnt_q != 2'd3, "queue count out of range")
endmodule

/* rtl/vna_front.sv */
// Front part: accepts words, reduces vertex indices and queues the commands.
`timescale 1ns / 1ps
module vna_front #(
	parameter int VERTEX_COUNT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  vna_pkg::in_word_t     item,
	input  vna_pkg::back_status_t status,
	input  logic                  queue_full,
	output logic                  push,
	output vna_pkg::in_word_t     push_word
);
	import vna_pkg::*;

	localparam bit NEED_MOD = VERTEX_COUNT < (1 << IDX_W);
	localparam logic [IDX_W:0] MOD_VAL = (IDX_W+1)'(VERTEX_COUNT);
	localparam int RCP_W = 2 * IDX_W;
	localparam int PROD_W = IDX_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << RCP_W) / VERTEX_COUNT);

	typedef enum logic [2:0] {
		F_IDLE   = 3'b001,
		F_REDUCE = 3'b010,
		F_PUSH   = 3'b100
	} fstate_t;

	fstate_t          state_q;
	in_word_t         item_q;
	logic [IDX_W-1:0] idx_q [3];
	logic [IDX_W-1:0] quo_q [3];
	logic [IDX_W:0]   rem_q [3];
	logic [1:0]       step_q;
	logic [IDX_W-1:0] quo_d [3];
	logic [IDX_W:0]   rem_d [3];

	// The reciprocal product gives a quotient that is low by at most one, so a single
	// compare and subtract finishes the remainder.
	always_comb begin
		logic [PROD_W-1:0] prod;
		logic [2*IDX_W:0]  qn;
		logic [IDX_W:0]    r;
		for (int i = 0; i < 3; i++) begin
			prod = PROD_W'(idx_q[i]) * PROD_W'(RECIP);
			quo_d[i] = prod[PROD_W-1:RCP_W];
			qn = (2*IDX_W+1)'(quo_q[i]) * (2*IDX_W+1)'(MOD_VAL);
			r = (IDX_W+1)'(idx_q[i]) - qn[IDX_W:0];
			if (r >= MOD_VAL) begin
				r = r - MOD_VAL;
			end
			rem_d[i] = r;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			item_q <= item;
			idx_q[0] <= item.vertex_a;
			idx_q[1] <= item.vertex_b;
			idx_q[2] <= item.vertex_c;
		end else if (state_q == F_REDUCE) begin
			if (step_q == 2'd0) begin
				for (int i = 0; i < 3; i++) begin
					quo_q[i] <= quo_d[i];
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= rem_d[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= 2'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					step_q <= 2'd0;
					if (start && !status.clearing && item.op != OP_NONE) begin
						state_q <= NEED_MOD ? F_REDUCE : F_PUSH;
					end
				end
				F_REDUCE: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd1) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!queue_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign busy = status.clearing || state_q != F_IDLE;
	assign push = state_q == F_PUSH && !queue_full;

	always_comb begin
		push_word = item_q;
		if (NEED_MOD) begin
			push_word.vertex_a = rem_q[0][IDX_W-1:0];
			push_word.vertex_b = rem_q[1][IDX_W-1:0];
			push_word.vertex_c = rem_q[2][IDX_W-1:0];
		end
	end
endmodule

/* rtl/vna_back.sv */
// Back part: position and normal stores, face normal unit and accumulation.
`timescale 1ns / 1ps
`include "vertex_normal_accumulation_defines.svh"
module vna_back #(
	parameter int VERTEX_COUNT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  vna_pkg::in_word_t     head,
	output logic                  pop,
	output vna_pkg::back_status_t status,
	output logic                  strobe,
	output vna_pkg::out_word_t    result
);
	import vna_pkg::*;

	localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int MAG_W = 34;
	localparam int SQ_W = 62;
	localparam logic signed [NRM_W:0] SAT_HI = (NRM_W+1)'((1 << (NRM_W-1)) - 1);
	localparam logic signed [NRM_W:0] SAT_LO = -SAT_HI - (NRM_W+1)'(1);

	typedef enum logic [14:0] {
		S_CLEAR = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_RDB   = 15'b000000000000100,
		S_RDC   = 15'b000000000001000,
		S_EDGE  = 15'b000000000010000,
		S_MUL   = 15'b000000000100000,
		S_SUB   = 15'b000000001000000,
		S_NORM  = 15'b000000010000000,
		S_SQ    = 15'b000000100000000,
		S_ACC   = 15'b000001000000000,
		S_SQRT  = 15'b000010000000000,
		S_DINIT = 15'b000100000000000,
		S_DIV   = 15'b001000000000000,
		S_NRD   = 15'b010000000000000,
		S_NWR   = 15'b100000000000000
	} bstate_t;

	bstate_t state_q;
	logic    read_out_q;

	logic [3*POS_W-1:0] pos_mem [VERTEX_COUNT];
	logic [3*NRM_W-1:0] nrm_mem [VERTEX_COUNT];
	logic [3*POS_W-1:0] pos_rd_q;
	logic [3*NRM_W-1:0] nrm_rd_q;
	logic [AW-1:0]      pos_addr;
	logic [AW-1:0]      nrm_addr;
	logic               pos_we;
	logic               nrm_we;
	logic [3*NRM_W-1:0] nrm_wdata;
	logic [AW-1:0]      clr_q;

	in_word_t                cmd_q;
	logic signed [POS_W-1:0] pa_q [3];
	logic signed [POS_W:0]   e1_q [3];
	logic signed [POS_W:0]   e2_q [3];
	logic signed [2*POS_W+1:0] p0_q, p1_q;
	logic [1:0]              k_q;
	logic [MAG_W-1:0]        mag_q [3];
	logic                    neg_q [3];
	logic [59:0]             sq_q;
	logic [SQ_W-1:0]         x_q, res_q, bit_q;
	logic [30:0]             rem_q;
	logic [14:0]             low_q;
	logic [14:0]             quo_q;
	logic [3:0]              dcnt_q;
	logic [14:0]             unit_q [3];
	logic                    strobe_q;
	out_word_t               result_q;

	logic signed [POS_W-1:0] rd_pos [3];
	logic signed [NRM_W-1:0] rd_nrm [3];
	logic [1:0]              u_sel, v_sel;
	logic signed [2*POS_W+2:0] diff;
	logic [MAG_W-1:0]        max_m;
	logic [SQ_W-1:0]         trial;
	logic [31:0]             rem2;
	logic [44:0]             numer;
	logic [IDX_W-1:0]        rmw_idx;
	logic signed [NRM_W-1:0] sat_val [3];

	assign rd_pos[0] = pos_rd_q[3*POS_W-1:2*POS_W];
	assign rd_pos[1] = pos_rd_q[2*POS_W-1:POS_W];
	assign rd_pos[2] = pos_rd_q[POS_W-1:0];
	assign rd_nrm[0] = nrm_rd_q[3*NRM_W-1:2*NRM_W];
	assign rd_nrm[1] = nrm_rd_q[2*NRM_W-1:NRM_W];
	assign rd_nrm[2] = nrm_rd_q[NRM_W-1:0];

	// Cross product component k pairs edges (u, v): x uses (y, z), y (z, x), z (x, y).
	always_comb begin
		case (k_q)
			2'd0: begin
				u_sel = 2'd1;
				v_sel = 2'd2;
			end
			2'd1: begin
				u_sel = 2'd2;
				v_sel = 2'd0;
			end
			default: begin
				u_sel = 2'd0;
				v_sel = 2'd1;
			end
		endcase
	end

	assign diff  = (2*POS_W+3)'(p0_q) - (2*POS_W+3)'(p1_q);
	assign trial = res_q + bit_q;
	assign rem2  = {rem_q, low_q[14]};
	assign numer = {mag_q[k_q][29:0], 14'b0} + 45'(res_q[30:1]);

	always_comb begin
		max_m = mag_q[0];
		if (mag_q[1] > max_m) begin
			max_m = mag_q[1];
		end
		if (mag_q[2] > max_m) begin
			max_m = mag_q[2];
		end
	end

	always_comb begin
		case (k_q)
			2'd0:    rmw_idx = cmd_q.vertex_a;
			2'd1:    rmw_idx = cmd_q.vertex_b;
			default: rmw_idx = cmd_q.vertex_c;
		endcase
	end

	always_comb begin
		logic signed [NRM_W:0] s;
		logic signed [UNIT_W-1:0] u;
		for (int i = 0; i < 3; i++) begin
			u = neg_q[i] ? -$signed({1'b0, unit_q[i]}) : $signed({1'b0, unit_q[i]});
			s = (NRM_W+1)'(rd_nrm[i]) + (NRM_W+1)'(u);
			if (s > SAT_HI) begin
				s = SAT_HI;
			end else if (s < SAT_LO) begin
				s = SAT_LO;
			end
			sat_val[i] = s[NRM_W-1:0];
		end
	end

	assign pop = state_q == S_IDLE && head_valid;

	always_comb begin
		pos_addr = AW'(cmd_q.vertex_a);
		case (state_q)
			S_IDLE:  pos_addr = AW'(head.vertex_a);
			S_RDB:   pos_addr = AW'(cmd_q.vertex_b);
			S_RDC:   pos_addr = AW'(cmd_q.vertex_c);
			default: pos_addr = AW'(cmd_q.vertex_a);
		endcase
		pos_we = pop && head.op == OP_LOAD;
		case (state_q)
			S_CLEAR:      nrm_addr = clr_q;
			S_NRD, S_NWR: nrm_addr = AW'(rmw_idx);
			default:      nrm_addr = AW'(head.vertex_a);
		endcase
		nrm_we    = state_q == S_CLEAR || state_q == S_NWR || pos_we;
		nrm_wdata = state_q == S_NWR ? {sat_val[0], sat_val[1], sat_val[2]} : '0;
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_addr] <= {head.pos_x, head.pos_y, head.pos_z};
		end
		pos_rd_q <= pos_mem[pos_addr];
	end

	always_ff @(posedge clk) begin
		if (nrm_we) begin
			nrm_mem[nrm_addr] <= nrm_wdata;
		end
		nrm_rd_q <= nrm_mem[nrm_addr];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= head;
			end
			S_RDB: begin
				for (int i = 0; i < 3; i++) begin
					pa_q[i] <= rd_pos[i];
				end
			end
			S_RDC: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= (POS_W+1)'(pa_q[i]) - (POS_W+1)'(rd_pos[i]);
				end
			end
			S_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e2_q[i] <= (POS_W+1)'(pa_q[i]) - (POS_W+1)'(rd_pos[i]);
				end
			end
			S_MUL: begin
				p0_q <= e1_q[u_sel] * e2_q[v_sel];
				p1_q <= e1_q[v_sel] * e2_q[u_sel];
			end
			S_SUB: begin
				neg_q[k_q] <= diff < 0;
				mag_q[k_q] <= diff < 0 ? MAG_W'(-diff) : MAG_W'(diff);
			end
			S_NORM: begin
				// Common shift that brings the largest magnitude into [2^29, 2^30).
				if (max_m[MAG_W-1:30] != '0) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end else if (!max_m[29] && max_m != '0) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
				x_q <= '0;
			end
			S_SQ: begin
				sq_q <= mag_q[k_q][29:0] * mag_q[k_q][29:0];
			end
			S_ACC: begin
				x_q   <= x_q + SQ_W'(sq_q);
				res_q <= '0;
				bit_q <= SQ_W'(1) << 60;
			end
			S_SQRT: begin
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DINIT: begin
				rem_q  <= 31'(numer[44:15]);
				low_q  <= numer[14:0];
				quo_q  <= '0;
				dcnt_q <= '0;
			end
			S_DIV: begin
				if (rem2 >= 32'(res_q[30:0])) begin
					rem_q <= 31'(rem2 - 32'(res_q[30:0]));
					quo_q <= {quo_q[13:0], 1'b1};
				end else begin
					rem_q <= rem2[30:0];
					quo_q <= {quo_q[13:0], 1'b0};
				end
				low_q  <= {low_q[13:0], 1'b0};
				dcnt_q <= dcnt_q + 4'd1;
				if (dcnt_q == 4'd14) begin
					unit_q[k_q] <= {quo_q[13:0], rem2 >= 32'(res_q[30:0])};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (read_out_q) begin
			result_q.vertex_out <= cmd_q.vertex_a;
			result_q.normal_x   <= rd_nrm[0];
			result_q.normal_y   <= rd_nrm[1];
			result_q.normal_z   <= rd_nrm[2];
		end
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			k_q        <= 2'd0;
			read_out_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q   <= read_out_q;
			read_out_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(VERTEX_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					k_q <= 2'd0;
					if (pop) begin
						if (head.op == OP_TRI) begin
							state_q <= S_RDB;
						end else if (head.op == OP_READ) begin
							read_out_q <= 1'b1;
						end
					end
				end
				S_RDB:  state_q <= S_RDC;
				S_RDC:  state_q <= S_EDGE;
				S_EDGE: state_q <= S_MUL;
				S_MUL:  state_q <= S_SUB;
				S_SUB: begin
					k_q <= k_q == 2'd2 ? 2'd0 : k_q + 2'd1;
					state_q <= k_q == 2'd2 ? S_NORM : S_MUL;
				end
				S_NORM: begin
					if (max_m == '0) begin
						state_q <= S_IDLE;
					end else if (max_m[MAG_W-1:30] == '0 && max_m[29]) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_ACC;
				S_ACC: begin
					k_q <= k_q == 2'd2 ? 2'd0 : k_q + 2'd1;
					state_q <= k_q == 2'd2 ? S_SQRT : S_SQ;
				end
				S_SQRT: begin
					if (bit_q[0]) begin
						state_q <= S_DINIT;
					end
				end
				S_DINIT: state_q <= S_DIV;
				S_DIV: begin
					if (dcnt_q == 4'd14) begin
						k_q <= k_q == 2'd2 ? 2'd0 : k_q + 2'd1;
						state_q <= k_q == 2'd2 ? S_NRD : S_DINIT;
					end
				end
				S_NRD: state_q <= S_NWR;
				S_NWR: begin
					k_q <= k_q == 2'd2 ? 2'd0 : k_q + 2'd1;
					state_q <= k_q == 2'd2 ? S_IDLE : S_NRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status.clearing = state_q == S_CLEAR;
	assign strobe = strobe_q;
	assign result = result_q;

	`VNA_ASSERT_IMP(a_unit_range, state_q == S_DIV && dcnt_q == 4'd14,
		{quo_q[13:0], rem2 >= 32'(res_q[30:0])} <= 15'(UNIT_ONE), "unit component too large")
	`VNA_ASSERT_IMP(a_strobe_src, strobe_q, $past(read_out_q), "result word without a read")
	`VNA_ASSERT_IMP(a_no_pop_busy, pop, state_q == S_IDLE, "command taken while busy")
endmodule

/* tb/vertex_normal_accumulation_checker.sv */
// Checker that predicts and compares the results of the vertex normal accumulation block.
`timescale 1ns / 1ps
module vertex_normal_accumulation_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  vna_pkg::in_word_t  item,
	input  logic               strobe,
	input  vna_pkg::out_word_t result,
	output int                 errors,
	output int                 pending
);
	import vna_pkg::*;

	logic signed [POS_W-1:0] pos_mem [0:4095][0:2];
	logic signed [NRM_W-1:0] acc_mem [0:4095][0:2];
	out_word_t expected_reads[$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [NRM_W-1:0] clamp_add(input logic signed [NRM_W-1:0] a,
			input longint d);
		longint s;
		longint hi;
		hi = (64'sd1 <<< (NRM_W - 1)) - 1;
		s = longint'(a) + d;
		if (s > hi)
			return hi[NRM_W-1:0];
		if (s < -hi - 1) begin
			s = -hi - 1;
			return s[NRM_W-1:0];
		end
		return s[NRM_W-1:0];
	endfunction

	task automatic add_face_normal(input int ia, input int ib, input int ic);
		longint e1 [3];
		longint e2 [3];
		longint c [3];
		longint unit [3];
		logic [63:0] mag [3];
		logic [63:0] m;
		logic [63:0] s;
		logic [63:0] r;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(pos_mem[ia][i]) - longint'(pos_mem[ib][i]);
			e2[i] = longint'(pos_mem[ia][i]) - longint'(pos_mem[ic][i]);
		end
		c[0] = e1[1] * e2[2] - e1[2] * e2[1];
		c[1] = e1[2] * e2[0] - e1[0] * e2[2];
		c[2] = e1[0] * e2[1] - e1[1] * e2[0];
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (c[i] < 0) ? -c[i] : c[i];
			if (mag[i] > m)
				m = mag[i];
		end
		if (m == 0)
			return;
		while (m >= (64'd1 << 30)) begin
			m = m >> 1;
			for (int i = 0; i < 3; i++)
				mag[i] = mag[i] >> 1;
		end
		while (m < (64'd1 << 29)) begin
			m = m << 1;
			for (int i = 0; i < 3; i++)
				mag[i] = mag[i] << 1;
		end
		s = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
		for (int i = 0; i < 3; i++) begin
			r = ((mag[i] << 14) + (s >> 1)) / s;
			unit[i] = (c[i] < 0) ? -longint'(r) : longint'(r);
		end
		for (int i = 0; i < 3; i++) begin
			acc_mem[ia][i] = clamp_add(acc_mem[ia][i], unit[i]);
			acc_mem[ib][i] = clamp_add(acc_mem[ib][i], unit[i]);
			acc_mem[ic][i] = clamp_add(acc_mem[ic][i], unit[i]);
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		for (int v = 0; v < 4096; v++)
			for (int i = 0; i < 3; i++) begin
				pos_mem[v][i] = 0;
				acc_mem[v][i] = 0;
			end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && start && !busy) begin
			case (item.op)
				OP_LOAD: begin
					pos_mem[item.vertex_a][0] = item.pos_x;
					pos_mem[item.vertex_a][1] = item.pos_y;
					pos_mem[item.vertex_a][2] = item.pos_z;
					for (int i = 0; i < 3; i++)
						acc_mem[item.vertex_a][i] = 0;
				end
				OP_TRI: add_face_normal(item.vertex_a, item.vertex_b, item.vertex_c);
				OP_READ: begin
					want.vertex_out = item.vertex_a;
					want.normal_x = acc_mem[item.vertex_a][0];
					want.normal_y = acc_mem[item.vertex_a][1];
					want.normal_z = acc_mem[item.vertex_a][2];
					expected_reads.insert(expected_reads.size(), want);
				end
				default: ;
			endcase
		end
		if (arst_n && strobe) begin
			if (expected_reads.size() == 0) begin
				errors <= errors + 1;
				$display("%0t: result word expected none actual %h", $time, result);
			end else begin
				want = expected_reads.pop_front();
				if (result !== want) begin
					errors <= errors + 1;
					$display("%0t: vertex expected %0d actual %0d", $time,
						want.vertex_out, result.vertex_out);
					$display("%0t: normal expected %0d %0d %0d actual %0d %0d %0d", $time,
						want.normal_x, want.normal_y, want.normal_z,
						result.normal_x, result.normal_y, result.normal_z);
				end
			end
		end
		pending <= expected_reads.size();
	end
endmodule

/* tb/tb_vertex_normal_accumulation.sv */
// Testbench top that drives commands into the vertex normal accumulation block.
`timescale 1ns / 1ps
module tb_vertex_normal_accumulation;
	import vna_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic strobe;
	in_word_t item = '0;
	out_word_t result;
	int errors;
	int pending;
	int idle_pct;
	int loaded [$];
	logic [4095:0] is_loaded = '0;

	always #10 clk = ~clk;

	vertex_normal_accumulation DUT (.clk, .arst_n, .start, .busy, .item, .strobe, .result);
	vertex_normal_accumulation_checker checker_i (.clk, .arst_n, .start, .busy, .item,
		.strobe, .result, .errors, .pending);

	task automatic send_word(input in_word_t w);
		while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		item <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		if (w.op == OP_LOAD && !is_loaded[w.vertex_a]) begin
			is_loaded[w.vertex_a] = 1;
			loaded.insert(loaded.size(), int'(w.vertex_a));
		end
	endtask

	function automatic in_word_t make_word(input op_t op, input int a, input int b, input int c,
			input int x, input int y, input int z);
		in_word_t w;
		w.op = op;
		w.vertex_a = IDX_W'(a);
		w.vertex_b = IDX_W'(b);
		w.vertex_c = IDX_W'(c);
		w.pos_x = POS_W'(x);
		w.pos_y = POS_W'(y);
		w.pos_z = POS_W'(z);
		return w;
	endfunction

	function automatic int any_loaded();
		return loaded[$urandom_range(loaded.size() - 1)];
	endfunction

	task automatic random_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			send_word(make_word(OP_LOAD, $urandom_range(4095), $urandom, $urandom,
				$urandom, $urandom, $urandom));
		else if (pick < 30)
			// Load within a few vertices so that triangles share them often.
			send_word(make_word(OP_LOAD, $urandom_range(15), 0, 0,
				$urandom_range(65535), $urandom_range(65535), $urandom_range(65535)));
		else if (pick < 65)
			send_word(make_word(OP_TRI, any_loaded(), any_loaded(), any_loaded(), $urandom,
				$urandom, $urandom));
		else if (pick < 95)
			send_word(make_word(OP_READ, ($urandom_range(1) ? any_loaded() :
				$urandom_range(4095)), $urandom, $urandom, $urandom, $urandom, $urandom));
		else
			send_word(make_word(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom));
	endtask

	initial begin
		#2000000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int hold;
		idle_pct = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		// Directed part: extremes, every op, degenerate and repeated-vertex triangles.
		send_word(make_word(OP_READ, 4095, 0, 0, 0, 0, 0));
		send_word(make_word(OP_LOAD, 0, 0, 0, 0, 0, 0));
		send_word(make_word(OP_LOAD, 1, 0, 0, 32767, 0, 0));
		send_word(make_word(OP_LOAD, 2, 0, 0, 0, 32767, -32768));
		send_word(make_word(OP_LOAD, 4095, 4095, 4095, -32768, -32768, -32768));
		send_word(make_word(OP_LOAD, 3, 0, 0, 64, 64, 0));
		send_word(make_word(OP_TRI, 0, 1, 2, 0, 0, 0));
		send_word(make_word(OP_TRI, 4095, 1, 2, 0, 0, 0));
		send_word(make_word(OP_TRI, 0, 0, 1, 0, 0, 0));
		send_word(make_word(OP_TRI, 0, 1, 1, 0, 0, 0));
		send_word(make_word(OP_TRI, 0, 3, 3, 0, 0, 0));
		send_word(make_word(OP_NONE, 4095, 4095, 4095, -1, -1, -1));
		for (int k = 0; k < 5; k++)
			send_word(make_word(OP_READ, k == 4 ? 4095 : k, 0, 0, 0, 0, 0));
		// Add the face normal of triangle 0, 1, 2 forty more times to its accumulators.
		for (int k = 0; k < 40; k++)
			send_word(make_word(OP_TRI, 0, 1, 2, 0, 0, 0));
		send_word(make_word(OP_READ, 0, 4095, 4095, 0, 0, 0));
		send_word(make_word(OP_LOAD, 0, 0, 0, 0, 0, 0));
		send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 0 : (phase == 1) ? 68 : 10;
			for (int n = 0; n < 150; n++)
				random_word();
		end
		start <= 0;
		hold = 0;
		while (pending != 0 && hold < 100000) begin
			@(posedge clk);
			hold++;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
